// ----- rtl/light_box_range_cull_core_defines.svh -----
// assertion macros for the light box range cull block
`ifndef LIGHT_BOX_RANGE_CULL_CORE_DEFINES_SVH
`define LIGHT_BOX_RANGE_CULL_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define LBRC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lbrc assertion failed");
`define LBRC_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lbrc assertion failed");
`else
`define LBRC_ASSERT_IMP(label, clk, rst, ante, cons)
`define LBRC_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/lbrc_pkg.sv -----
// shared types and constants for the light box range cull block
`timescale 1ns / 1ps
package lbrc_pkg;

  localparam int LIGHT_SLOTS_DEF = 32;

  localparam int OP_W       = 1;
  localparam int SLOT_IN_W  = 5;
  localparam int POS_W      = 24;
  localparam int REACH_W    = 23;
  localparam int SIZE_W     = 14;
  localparam int CELL_W     = 8;
  localparam int LEVEL_W    = 4;
  localparam int HEIGHT_W   = 16;
  localparam int MASK_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // internal arithmetic widths
  localparam int COORD_W = 32;
  localparam int DIST_W  = 25;
  localparam int MUL_W   = 25;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int ACC_W   = PROD_W + 2;
  localparam int BOXP_W  = CELL_W + SIZE_W;
  localparam int ENTRY_W = 3 * POS_W + REACH_W;

  localparam logic [OP_W-1:0] OP_LOAD = 1'b0;
  localparam logic [OP_W-1:0] OP_TEST = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SQUARE_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y    = 2'd2;

  localparam logic [SIZE_W-1:0] SQUARE_SIZE_RST = 14'd256;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BOX_X,
    ST_BOX_Y,
    ST_BOX_XH,
    ST_BOX_YH,
    ST_FETCH,
    ST_GAP,
    ST_SQ_X,
    ST_SQ_Y,
    ST_SQ_Z,
    ST_SQ_R,
    ST_CMP,
    ST_DONE
  } state_t;

endpackage

// ----- rtl/lbrc_channels.sv -----
// valid/ready channel interfaces for requests, results and configuration
`timescale 1ns / 1ps
interface lbrc_req_if;
  logic                                valid;
  logic                                ready;
  logic [lbrc_pkg::OP_W-1:0]           op;
  logic [lbrc_pkg::SLOT_IN_W-1:0]      light_slot;
  logic signed [lbrc_pkg::POS_W-1:0]   light_x;
  logic signed [lbrc_pkg::POS_W-1:0]   light_y;
  logic signed [lbrc_pkg::POS_W-1:0]   light_z;
  logic [lbrc_pkg::REACH_W-1:0]        light_reach;
  logic [lbrc_pkg::CELL_W-1:0]         cell_x;
  logic [lbrc_pkg::CELL_W-1:0]         cell_y;
  logic [lbrc_pkg::LEVEL_W-1:0]        square_level;
  logic [lbrc_pkg::HEIGHT_W-1:0]       min_height;
  logic [lbrc_pkg::HEIGHT_W-1:0]       max_height;
  logic [lbrc_pkg::MASK_W-1:0]         light_mask;

  modport source (output valid, op, light_slot, light_x, light_y, light_z, light_reach,
                  cell_x, cell_y, square_level, min_height, max_height, light_mask,
                  input ready);
  modport sink (input valid, op, light_slot, light_x, light_y, light_z, light_reach,
                cell_x, cell_y, square_level, min_height, max_height, light_mask,
                output ready);
endinterface

interface lbrc_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [lbrc_pkg::MASK_W-1:0] in_range_mask;

  modport source (output valid, in_range_mask, input ready);
  modport sink (input valid, in_range_mask, output ready);
endinterface

interface lbrc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [lbrc_pkg::CFG_IDX_W-1:0]  index;
  logic [lbrc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/lbrc_ram.sv -----
// generic single write port ram with registered read
`timescale 1ns / 1ps
module lbrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/light_box_range_cull_core.sv -----
// light box range cull: light table and sequenced sphere-box overlap test
//
//  channel | role   | handshake          | payload
//  req     | sink   | valid/ready        | op, light fields, square fields, light_mask
//  rsp     | source | valid/ready        | in_range_mask
//  cfg     | sink   | valid/ready (rdy=1)| index, data
//
// a load transaction writes the table in its accept cycle and answers from the done state
// a test transaction builds the box, then for each masked light fetches its entry and
// forms the axis gaps, using the single multiplier for the box corners, the three gap squares
// and the squared reach, then compares, before its result is offered
// req is not ready while a transaction is in flight; a stalled result holds the block
// synchronous reset clears control and configuration; the light table is not cleared
`timescale 1ns / 1ps
`include "light_box_range_cull_core_defines.svh"
module light_box_range_cull_core #(
  parameter int LIGHT_SLOTS = lbrc_pkg::LIGHT_SLOTS_DEF
) (
  input logic      clk,
  input logic      rst,
  lbrc_req_if.sink   req,
  lbrc_rsp_if.source rsp,
  lbrc_cfg_if.sink   cfg
);

  localparam int SLOT_W  = (LIGHT_SLOTS > 1) ? $clog2(LIGHT_SLOTS) : 1;
  localparam int COORD_W = lbrc_pkg::COORD_W;
  localparam int DIST_W  = lbrc_pkg::DIST_W;
  localparam int MUL_W   = lbrc_pkg::MUL_W;
  localparam int PROD_W  = lbrc_pkg::PROD_W;
  localparam int ACC_W   = lbrc_pkg::ACC_W;
  localparam int POS_W   = lbrc_pkg::POS_W;
  localparam int REACH_W = lbrc_pkg::REACH_W;
  localparam int BOXP_W  = lbrc_pkg::BOXP_W;
  localparam int ENTRY_W = lbrc_pkg::ENTRY_W;

  lbrc_pkg::state_t state, state_next;

  // configuration
  logic [lbrc_pkg::SIZE_W-1:0]            square_size;
  logic signed [lbrc_pkg::CFG_DATA_W-1:0] origin_x;
  logic signed [lbrc_pkg::CFG_DATA_W-1:0] origin_y;

  // latched test item and box
  logic [lbrc_pkg::CELL_W-1:0]  cx;
  logic [lbrc_pkg::CELL_W-1:0]  cy;
  logic [lbrc_pkg::LEVEL_W-1:0] lvl;
  logic signed [COORD_W-1:0]    zlo;
  logic signed [COORD_W-1:0]    zhi;
  logic signed [COORD_W-1:0]    side;
  logic signed [COORD_W-1:0]    xlo;
  logic signed [COORD_W-1:0]    xhi;
  logic signed [COORD_W-1:0]    ylo;
  logic signed [COORD_W-1:0]    yhi;

  // per light work
  logic [LIGHT_SLOTS-1:0] pend;
  logic [LIGHT_SLOTS-1:0] res;
  logic [SLOT_W-1:0]      cur;
  logic [SLOT_W-1:0]      pick;
  logic [DIST_W-1:0]      dx;
  logic [DIST_W-1:0]      dy;
  logic [DIST_W-1:0]      dz;
  logic [REACH_W-1:0]     rad;
  logic [MUL_W-1:0]       mul_a;
  logic [MUL_W-1:0]       mul_b;
  logic [PROD_W-1:0]      mul_p;
  logic [PROD_W-1:0]      prod;
  logic [ACC_W-1:0]       acc;

  // output register
  logic                        out_valid;
  logic [lbrc_pkg::MASK_W-1:0] out_mask;
  logic                        out_load;

  // table port
  logic               ram_we;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  logic signed [POS_W-1:0] rd_x;
  logic signed [POS_W-1:0] rd_y;
  logic signed [POS_W-1:0] rd_z;
  logic [REACH_W-1:0]      rd_r;

  logic accept;
  logic slot_ok;

  function automatic logic [DIST_W-1:0] gap(input logic signed [COORD_W-1:0] p,
                                            input logic signed [COORD_W-1:0] lo,
                                            input logic signed [COORD_W-1:0] hi);
    logic signed [COORD_W-1:0] d;
    if (p < lo) begin
      d = lo - p;
    end else if (p > hi) begin
      d = p - hi;
    end else begin
      d = '0;
    end
    return d[DIST_W-1:0];
  endfunction

  assign req.ready = (state == lbrc_pkg::ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign slot_ok   = int'(req.light_slot) < LIGHT_SLOTS;
  assign cfg.ready = 1'b1;

  assign rsp.valid         = out_valid;
  assign rsp.in_range_mask = out_mask;

  assign ram_we    = accept && (req.op == lbrc_pkg::OP_LOAD) && slot_ok;
  assign ram_wdata = {req.light_x, req.light_y, req.light_z, req.light_reach};
  assign rd_x      = ram_rdata[ENTRY_W-1 -: POS_W];
  assign rd_y      = ram_rdata[ENTRY_W-POS_W-1 -: POS_W];
  assign rd_z      = ram_rdata[REACH_W+POS_W-1 -: POS_W];
  assign rd_r      = ram_rdata[REACH_W-1:0];

  lbrc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (LIGHT_SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (req.light_slot[SLOT_W-1:0]),
    .wdata (ram_wdata),
    .raddr (pick),
    .rdata (ram_rdata)
  );

  // lowest pending light
  always_comb begin
    pick = '0;
    for (int i = LIGHT_SLOTS - 1; i >= 0; i--) begin
      if (pend[i]) begin
        pick = SLOT_W'(i);
      end
    end
  end

  // shared multiplier operand select
  always_comb begin
    case (state)
      lbrc_pkg::ST_BOX_X: begin
        mul_a = MUL_W'(cx);
        mul_b = MUL_W'(square_size);
      end
      lbrc_pkg::ST_BOX_Y: begin
        mul_a = MUL_W'(cy);
        mul_b = MUL_W'(square_size);
      end
      lbrc_pkg::ST_SQ_X: begin
        mul_a = dx;
        mul_b = dx;
      end
      lbrc_pkg::ST_SQ_Y: begin
        mul_a = dy;
        mul_b = dy;
      end
      lbrc_pkg::ST_SQ_Z: begin
        mul_a = dz;
        mul_b = dz;
      end
      lbrc_pkg::ST_SQ_R: begin
        mul_a = MUL_W'(rad);
        mul_b = MUL_W'(rad);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p    = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign out_load = (state == lbrc_pkg::ST_DONE) && (!out_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lbrc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      lbrc_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = (req.op == lbrc_pkg::OP_TEST) ? lbrc_pkg::ST_BOX_X
                                                     : lbrc_pkg::ST_DONE;
        end
      end
      lbrc_pkg::ST_BOX_X:  state_next = lbrc_pkg::ST_BOX_Y;
      lbrc_pkg::ST_BOX_Y:  state_next = lbrc_pkg::ST_BOX_XH;
      lbrc_pkg::ST_BOX_XH: state_next = lbrc_pkg::ST_BOX_YH;
      lbrc_pkg::ST_BOX_YH: state_next = lbrc_pkg::ST_FETCH;
      lbrc_pkg::ST_FETCH: begin
        state_next = (pend == '0) ? lbrc_pkg::ST_DONE : lbrc_pkg::ST_GAP;
      end
      lbrc_pkg::ST_GAP:  state_next = lbrc_pkg::ST_SQ_X;
      lbrc_pkg::ST_SQ_X: state_next = lbrc_pkg::ST_SQ_Y;
      lbrc_pkg::ST_SQ_Y: state_next = lbrc_pkg::ST_SQ_Z;
      lbrc_pkg::ST_SQ_Z: state_next = lbrc_pkg::ST_SQ_R;
      lbrc_pkg::ST_SQ_R: state_next = lbrc_pkg::ST_CMP;
      lbrc_pkg::ST_CMP:  state_next = lbrc_pkg::ST_FETCH;
      lbrc_pkg::ST_DONE: begin
        if (out_load) begin
          state_next = lbrc_pkg::ST_IDLE;
        end
      end
      default: state_next = lbrc_pkg::ST_IDLE;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      square_size <= lbrc_pkg::SQUARE_SIZE_RST;
      origin_x    <= '0;
      origin_y    <= '0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        lbrc_pkg::CFG_SQUARE_SIZE: square_size <= cfg.data[lbrc_pkg::SIZE_W-1:0];
        lbrc_pkg::CFG_ORIGIN_X:    origin_x    <= cfg.data;
        lbrc_pkg::CFG_ORIGIN_Y:    origin_y    <= cfg.data;
        default: ;
      endcase
    end
  end

  // result handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_mask <= lbrc_pkg::MASK_W'(res);
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    prod <= mul_p;
    if (accept) begin
      cx   <= req.cell_x;
      cy   <= req.cell_y;
      lvl  <= req.square_level;
      zlo  <= COORD_W'(req.min_height);
      zhi  <= COORD_W'(req.max_height);
      pend <= (req.op == lbrc_pkg::OP_TEST) ? req.light_mask[LIGHT_SLOTS-1:0] : '0;
      res  <= '0;
    end
    case (state)
      lbrc_pkg::ST_BOX_X: begin
        side <= COORD_W'(square_size) << lvl;
      end
      lbrc_pkg::ST_BOX_Y: begin
        xlo <= COORD_W'(prod[BOXP_W-1:0]) + COORD_W'(origin_x);
      end
      lbrc_pkg::ST_BOX_XH: begin
        ylo <= COORD_W'(prod[BOXP_W-1:0]) + COORD_W'(origin_y);
        xhi <= xlo + side;
      end
      lbrc_pkg::ST_BOX_YH: begin
        yhi <= ylo + side;
      end
      lbrc_pkg::ST_FETCH: begin
        cur        <= pick;
        pend[pick] <= 1'b0;
      end
      lbrc_pkg::ST_GAP: begin
        dx  <= gap(COORD_W'(rd_x), xlo, xhi);
        dy  <= gap(COORD_W'(rd_y), ylo, yhi);
        dz  <= gap(COORD_W'(rd_z), zlo, zhi);
        rad <= rd_r;
      end
      lbrc_pkg::ST_SQ_Y: begin
        acc <= ACC_W'(prod);
      end
      lbrc_pkg::ST_SQ_Z, lbrc_pkg::ST_SQ_R: begin
        acc <= acc + ACC_W'(prod);
      end
      lbrc_pkg::ST_CMP: begin
        // prod holds reach squared here
        if (acc < ACC_W'(prod)) begin
          res[cur] <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  `LBRC_ASSERT_NXT(a_busy_after_accept, clk, rst, accept, !req.ready)
  `LBRC_ASSERT_IMP(a_cmp_slot_retired, clk, rst, state == lbrc_pkg::ST_CMP, !pend[cur])
  `LBRC_ASSERT_NXT(a_result_offered, clk, rst, out_load, out_valid)

endmodule

// ----- dv/light_cull_board_pkg.sv -----
// request type and range mask scoreboard for the light box range cull testbench
`timescale 1ns / 1ps
package light_cull_board_pkg;
  import lbrc_pkg::*;

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic [SLOT_IN_W-1:0] light_slot;
    logic [POS_W-1:0]     light_x;
    logic [POS_W-1:0]     light_y;
    logic [POS_W-1:0]     light_z;
    logic [REACH_W-1:0]   light_reach;
    logic [CELL_W-1:0]    cell_x;
    logic [CELL_W-1:0]    cell_y;
    logic [LEVEL_W-1:0]   square_level;
    logic [HEIGHT_W-1:0]  min_height;
    logic [HEIGHT_W-1:0]  max_height;
    logic [MASK_W-1:0]    light_mask;
  } cull_req_t;

  class light_cull_board;
    logic signed [POS_W-1:0] pos_x [LIGHT_SLOTS_DEF];
    logic signed [POS_W-1:0] pos_y [LIGHT_SLOTS_DEF];
    logic signed [POS_W-1:0] pos_z [LIGHT_SLOTS_DEF];
    logic [REACH_W-1:0]      reach [LIGHT_SLOTS_DEF];
    logic [SIZE_W-1:0]       square_size;
    logic signed [POS_W-1:0] origin_x;
    logic signed [POS_W-1:0] origin_y;
    logic [MASK_W-1:0]       expected_masks [$];
    int                      errors;

    function new();
      foreach (pos_x[i]) begin
        pos_x[i] = '0;
        pos_y[i] = '0;
        pos_z[i] = '0;
        reach[i] = '0;
      end
      square_size = SQUARE_SIZE_RST;
      origin_x = '0;
      origin_y = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_SQUARE_SIZE: square_size = val[SIZE_W-1:0];
        CFG_ORIGIN_X:    origin_x = val[POS_W-1:0];
        CFG_ORIGIN_Y:    origin_y = val[POS_W-1:0];
        default: ;
      endcase
    endfunction

    // below lo is tested first, so an inverted range measures to its minimum from below
    static function u64_t axis_gap(longint p, longint lo, longint hi);
      if (p < lo) return u64_t'(lo - p);
      if (p > hi) return u64_t'(p - hi);
      return 0;
    endfunction

    function logic [MASK_W-1:0] cull_square(cull_req_t r);
      longint            side, xlo, ylo, xhi, yhi, zlo, zhi;
      u64_t              dx, dy, dz, sum, rr;
      logic [MASK_W-1:0] hits;
      hits = '0;
      side = longint'(square_size) << r.square_level;
      xlo = longint'(r.cell_x) * longint'(square_size) + longint'(origin_x);
      ylo = longint'(r.cell_y) * longint'(square_size) + longint'(origin_y);
      xhi = xlo + side;
      yhi = ylo + side;
      zlo = longint'(r.min_height);
      zhi = longint'(r.max_height);
      for (int i = 0; i < LIGHT_SLOTS_DEF; i++) begin
        if (r.light_mask[i]) begin
          dx = axis_gap(longint'(pos_x[i]), xlo, xhi);
          dy = axis_gap(longint'(pos_y[i]), ylo, yhi);
          dz = axis_gap(longint'(pos_z[i]), zlo, zhi);
          sum = dx * dx + dy * dy + dz * dz;
          rr = u64_t'(reach[i]) * u64_t'(reach[i]);
          if (sum < rr) hits[i] = 1'b1;
        end
      end
      return hits;
    endfunction

    function void note_request(cull_req_t r);
      if (r.op == OP_LOAD) begin
        pos_x[r.light_slot] = r.light_x;
        pos_y[r.light_slot] = r.light_y;
        pos_z[r.light_slot] = r.light_z;
        reach[r.light_slot] = r.light_reach;
        expected_masks.push_back('0);
      end else begin
        expected_masks.push_back(cull_square(r));
      end
    endfunction

    function void check_mask(logic [MASK_W-1:0] got);
      logic [MASK_W-1:0] want;
      if (expected_masks.size() == 0) begin
        $display("%0t: in_range_mask %h arrived with nothing expected", $time, got);
        errors++;
        return;
      end
      want = expected_masks.pop_front();
      if (got !== want) begin
        $display("%0t: in_range_mask mismatch, expected %h, actual %h", $time, want, got);
        errors++;
      end
    endfunction

    function int pending();
      return expected_masks.size();
    endfunction
  endclass

endpackage

// ----- dv/testbench.sv -----
// top level testbench for the light box range cull core
`timescale 1ns / 1ps
module testbench;
  import lbrc_pkg::*;
  import light_cull_board_pkg::*;

  localparam int PHASES          = 10;
  localparam int ITEMS_PER_PHASE = 124;
  localparam int DRAIN_PAD       = 8;
  localparam int LONG_HOLD       = 3000;
  localparam int HOLD_PHASE      = 3;
  localparam longint CYCLE_LIMIT = 4_000_000;
  localparam int RND             = 32'h7FFF_FFFF;

  logic clk = 1'b0;
  logic rst;
  always #6 clk = ~clk;

  lbrc_req_if req ();
  lbrc_rsp_if rsp ();
  lbrc_cfg_if cfg ();

  light_box_range_cull_core DUT (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp),
    .cfg(cfg)
  );

  light_cull_board board;

  logic [SIZE_W-1:0]       cur_size;
  logic signed [POS_W-1:0] cur_ox;
  logic signed [POS_W-1:0] cur_oy;
  logic [MASK_W-1:0]       loaded_slots;
  int                      hot_cx;
  int                      hot_cy;
  bit                      no_gaps;
  bit                      hold_rsp;
  longint                  cycle_count = 0;

  int size_plan [PHASES] = '{256, 1, 16383, 0, 8192, RND, 32, RND, 16383, 1};
  int ox_plan   [PHASES] = '{0, -8388608, 8388607, RND, 0, RND, 8388607, -8388608, RND, 0};
  int oy_plan   [PHASES] = '{0, 8388607, -8388608, 0, RND, RND, -8388608, 8388607, 0, RND};

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 20);
    return $urandom_range(40, 150);
  endfunction

  function automatic logic [POS_W-1:0] clamp_pos(input longint v);
    if (v > longint'(8388607)) return 24'h7FFFFF;
    if (v < -longint'(8388608)) return 24'h800000;
    return v[POS_W-1:0];
  endfunction

  function automatic int clamp_cell(input int c);
    if (c < 0) return 0;
    if (c > 255) return 255;
    return c;
  endfunction

  function automatic cull_req_t random_fields();
    cull_req_t it;
    it.op           = OP_W'($urandom);
    it.light_slot   = SLOT_IN_W'($urandom);
    it.light_x      = POS_W'($urandom);
    it.light_y      = POS_W'($urandom);
    it.light_z      = POS_W'($urandom);
    it.light_reach  = REACH_W'($urandom);
    it.cell_x       = CELL_W'($urandom);
    it.cell_y       = CELL_W'($urandom);
    it.square_level = LEVEL_W'($urandom);
    it.min_height   = HEIGHT_W'($urandom);
    it.max_height   = HEIGHT_W'($urandom);
    it.light_mask   = MASK_W'($urandom);
    return it;
  endfunction

  function automatic cull_req_t make_load(input logic [SLOT_IN_W-1:0] slot,
                                          input logic [POS_W-1:0] x, y, z,
                                          input logic [REACH_W-1:0] rch);
    cull_req_t it;
    it = random_fields();
    it.op = OP_LOAD;
    it.light_slot = slot;
    it.light_x = x;
    it.light_y = y;
    it.light_z = z;
    it.light_reach = rch;
    loaded_slots[slot] = 1'b1;
    return it;
  endfunction

  // masks only name loaded entries, the table holds nothing defined before a load
  function automatic cull_req_t make_test(input int cx, cy, lvl,
                                          input logic [HEIGHT_W-1:0] lo, hi,
                                          input logic [MASK_W-1:0] mask);
    cull_req_t it;
    it = random_fields();
    it.op = OP_TEST;
    it.cell_x = CELL_W'(cx);
    it.cell_y = CELL_W'(cy);
    it.square_level = LEVEL_W'(lvl);
    it.min_height = lo;
    it.max_height = hi;
    it.light_mask = mask & loaded_slots;
    return it;
  endfunction

  // mostly lights and squares clustered round one hot cell, so hits and misses both occur
  function automatic cull_req_t rand_item();
    cull_req_t         it;
    int                r, span, lvl;
    longint            bx, by;
    logic [HEIGHT_W-1:0] lo, hi;
    logic [MASK_W-1:0] mask;
    logic [REACH_W-1:0] rch;
    r = $urandom_range(0, 99);
    span = (int'(cur_size) + 16) * 12;
    bx = longint'(cur_ox) + longint'(hot_cx) * longint'(cur_size);
    by = longint'(cur_oy) + longint'(hot_cy) * longint'(cur_size);
    if (r < 15) begin
      it = random_fields();
      if (it.op == OP_LOAD) loaded_slots[it.light_slot] = 1'b1;
      else it.light_mask &= loaded_slots;
    end else if (r < 45) begin
      r = $urandom_range(0, 9);
      if (r == 0) rch = '0;
      else if (r == 1) rch = REACH_W'($urandom);
      else rch = REACH_W'($urandom_range(0, 2 * span));
      it = make_load(SLOT_IN_W'($urandom),
                     clamp_pos(bx + longint'($urandom_range(0, 2 * span)) - longint'(span)),
                     clamp_pos(by + longint'($urandom_range(0, 2 * span)) - longint'(span)),
                     clamp_pos(longint'($urandom_range(0, 72000)) - 4000),
                     rch);
    end else begin
      r = $urandom_range(0, 99);
      if (r < 70) lvl = $urandom_range(0, 2);
      else if (r < 95) lvl = $urandom_range(3, 8);
      else lvl = $urandom_range(9, 15);
      lo = HEIGHT_W'($urandom);
      if ($urandom_range(0, 9) == 0) hi = HEIGHT_W'($urandom_range(0, lo));
      else hi = HEIGHT_W'($urandom_range(lo, 65535));
      if ($urandom_range(0, 4) == 0) mask = MASK_W'(1) << $urandom_range(0, 31);
      else mask = MASK_W'($urandom);
      it = make_test(clamp_cell(hot_cx + int'($urandom_range(0, 4)) - 2),
                     clamp_cell(hot_cy + int'($urandom_range(0, 4)) - 2),
                     lvl, lo, hi, mask);
    end
    return it;
  endfunction

  // valid stays high on return, so a back-to-back transaction needs no second assignment
  task automatic send_item(input cull_req_t it);
    req.valid        <= 1'b1;
    req.op           <= it.op;
    req.light_slot   <= it.light_slot;
    req.light_x      <= it.light_x;
    req.light_y      <= it.light_y;
    req.light_z      <= it.light_z;
    req.light_reach  <= it.light_reach;
    req.cell_x       <= it.cell_x;
    req.cell_y       <= it.cell_y;
    req.square_level <= it.square_level;
    req.min_height   <= it.min_height;
    req.max_height   <= it.max_height;
    req.light_mask   <= it.light_mask;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    board.note_request(it);
  endtask

  task automatic pause_req(input int n);
    if (n > 0) begin
      req.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain_block();
    req.valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  task automatic program_regs(input logic [SIZE_W-1:0] sz,
                              input logic [POS_W-1:0] ox, oy);
    logic [CFG_IDX_W-1:0]  idxs [3];
    logic [CFG_DATA_W-1:0] vals [3];
    idxs = '{CFG_SQUARE_SIZE, CFG_ORIGIN_X, CFG_ORIGIN_Y};
    // upper data bits of the size register carry junk, they must be dropped
    vals = '{{(CFG_DATA_W - SIZE_W)'($urandom), sz}, ox, oy};
    for (int k = 0; k < 3; k++) begin
      cfg.valid <= 1'b1;
      cfg.index <= idxs[k];
      cfg.data  <= vals[k];
      @(posedge clk);
      while (!cfg.ready) @(posedge clk);
      board.write_reg(idxs[k], vals[k]);
    end
    cfg.valid <= 1'b0;
    cur_size = sz;
    cur_ox = ox;
    cur_oy = oy;
  endtask

  function automatic logic [POS_W-1:0] plan_origin(input int p);
    if (p == RND) return POS_W'($urandom);
    return POS_W'(p);
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // result side: checks every transaction and throttles ready
  initial begin : rsp_side
    int idle_left;
    idle_left = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp.valid === 1'b1 && rsp.ready === 1'b1) board.check_mask(rsp.in_range_mask);
      if (hold_rsp) begin
        hold_rsp = 1'b0;
        idle_left = LONG_HOLD;
      end
      if (idle_left > 0) begin
        rsp.ready <= 1'b0;
        idle_left--;
      end else begin
        rsp.ready <= 1'b1;
        if (!no_gaps) idle_left = pick_gap();
      end
    end
  end

  initial begin
    board = new();
    cur_size = SQUARE_SIZE_RST;
    cur_ox = '0;
    cur_oy = '0;
    loaded_slots = '0;
    hot_cx = 0;
    hot_cy = 0;
    no_gaps = 1'b0;
    hold_rsp = 1'b0;
    rst <= 1'b1;
    req.valid <= 1'b0;
    req.op <= OP_LOAD;
    req.light_slot <= '0;
    req.light_x <= '0;
    req.light_y <= '0;
    req.light_z <= '0;
    req.light_reach <= '0;
    req.cell_x <= '0;
    req.cell_y <= '0;
    req.square_level <= '0;
    req.min_height <= '0;
    req.max_height <= '0;
    req.light_mask <= '0;
    cfg.valid <= 1'b0;
    cfg.index <= CFG_SQUARE_SIZE;
    cfg.data <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed part under the reset configuration: 256 square, origin at zero
    send_item(make_load(5'd0, 24'h000000, 24'h000000, 24'h000000, 23'd1));
    pause_req(pick_gap());
    send_item(make_load(5'd1, 24'h800000, 24'h800000, 24'h800000, 23'h7FFFFF));
    pause_req(pick_gap());
    send_item(make_load(5'd2, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 23'h7FFFFF));
    pause_req(pick_gap());
    // zero reach never hits, even from inside the box
    send_item(make_load(5'd3, 24'd128, 24'd128, 24'd50, 23'd0));
    pause_req(pick_gap());
    // 44 past the face: reach 45 hits, reach 44 sits exactly on the bound and misses
    send_item(make_load(5'd4, 24'd300, 24'd128, 24'd50, 23'd45));
    pause_req(pick_gap());
    send_item(make_load(5'd5, 24'd300, 24'd128, 24'd50, 23'd44));
    pause_req(pick_gap());
    send_item(make_load(5'd30, 24'd100, 24'd100, 24'd5, 23'd196));
    pause_req(pick_gap());
    send_item(make_load(5'd31, 24'hFFFFFF, 24'hFFFFFF, 24'd70000, 23'd5000));
    pause_req(pick_gap());
    send_item(make_test(0, 0, 0, 16'd0, 16'd100, '1));
    pause_req(pick_gap());
    send_item(make_test(255, 255, 15, 16'd0, 16'hFFFF, '1));
    pause_req(pick_gap());
    // inverted height ranges measure to the minimum from below
    send_item(make_test(0, 0, 0, 16'd200, 16'd10, '1));
    pause_req(pick_gap());
    send_item(make_test(0, 0, 0, 16'd210, 16'd10, '1));
    pause_req(pick_gap());
    send_item(make_test(0, 0, 0, 16'd0, 16'd100, '0));
    pause_req(pick_gap());
    send_item(make_test(0, 0, 8, 16'd0, 16'd0, '1));
    pause_req(pick_gap());
    send_item(make_test(128, 64, 3, 16'hFFFF, 16'hFFFF, '1));
    pause_req(pick_gap());
    send_item(make_load(5'd0, 24'd1000, 24'd1000, 24'd0, 23'h7FFFFF));
    pause_req(pick_gap());
    send_item(make_test(0, 0, 0, 16'd0, 16'd100, '1));
    pause_req(pick_gap());

    for (int ph = 0; ph < PHASES; ph++) begin
      drain_block();
      program_regs(size_plan[ph] == RND ? SIZE_W'($urandom_range(1, 16383))
                                        : SIZE_W'(size_plan[ph]),
                   plan_origin(ox_plan[ph]), plan_origin(oy_plan[ph]));
      hot_cx = $urandom_range(0, 255);
      hot_cy = $urandom_range(0, 255);
      no_gaps = (ph == 2 || ph == 7);
      if (ph == HOLD_PHASE) hold_rsp = 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_item(rand_item());
        pause_req(no_gaps ? 0 : pick_gap());
      end
    end

    drain_block();
    if (board.errors == 0 && board.pending() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
